// ===== hw/rtl/srwc_pkg.sv =====
package srwc_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned SIZE_W    = 25;
    localparam int unsigned END_W     = 33;
    localparam int unsigned ALU_W     = 34;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 33;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_MASK = 2'd2;

    localparam logic [ADDR_W-1:0] WIN_BASE_RST = 32'h0000_0000;
    localparam logic [END_W-1:0]  WIN_END_RST  = 33'h0_0010_0000;
    localparam logic [ADDR_W-1:0] OFS_MASK_RST = 32'h000F_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOCAL,
        ST_ROOM,
        ST_CMP,
        ST_DEV,
        ST_EMIT,
        ST_OFS,
        ST_BYTES,
        ST_LO,
        ST_HI
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef logic [ALU_W-1:0] t_alu_word;

endpackage

// ===== hw/rtl/srwc_region_if.sv =====
interface srwc_region_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [srwc_pkg::ADDR_W-1:0]   region_addr_hi;
    logic [srwc_pkg::ADDR_W-1:0]   region_addr_lo;
    logic [srwc_pkg::SIZE_W-1:0]   region_size;
    logic [srwc_pkg::ADDR_W-1:0]   device_base;
    logic                          last_region;

    modport source (
        output valid, mode, region_addr_hi, region_addr_lo, region_size,
               device_base, last_region,
        input  ready
    );

    modport sink (
        input  valid, mode, region_addr_hi, region_addr_lo, region_size,
               device_base, last_region,
        output ready
    );
endinterface

// ===== hw/rtl/srwc_chunk_if.sv =====
interface srwc_chunk_if;
    logic                          valid;
    logic                          ready;
    logic [srwc_pkg::ADDR_W-1:0]   bar_addr_hi;
    logic [srwc_pkg::ADDR_W-1:0]   bar_addr_lo;
    logic [srwc_pkg::ADDR_W-1:0]   src_addr;
    logic [srwc_pkg::ADDR_W-1:0]   dst_addr;
    logic [srwc_pkg::SIZE_W-1:0]   chunk_size;
    logic                          last_chunk;

    modport source (
        output valid, bar_addr_hi, bar_addr_lo, src_addr, dst_addr,
               chunk_size, last_chunk,
        input  ready
    );

    modport sink (
        input  valid, bar_addr_hi, bar_addr_lo, src_addr, dst_addr,
               chunk_size, last_chunk,
        output ready
    );
endinterface

// ===== hw/rtl/srwc_alu.sv =====
// Shared add/subtract unit; the top bit of a subtraction is the borrow
module srwc_alu (
    input  srwc_pkg::t_alu_op   i_op,
    input  srwc_pkg::t_alu_word i_a,
    input  srwc_pkg::t_alu_word i_b,
    output srwc_pkg::t_alu_word o_res
);
    always_comb begin
        unique case (i_op)
            srwc_pkg::ALU_ADD: o_res = i_a + i_b;
            srwc_pkg::ALU_SUB: o_res = i_a - i_b;
            default:           o_res = i_a + i_b;
        endcase
    end
endmodule

// ===== hw/rtl/scatter_region_window_chunker_core.sv =====
// Channel   | Modport | Handshake     | Moves
// ----------+---------+---------------+----------------------------------------
// i_region  | sink    | valid / ready | one scatter region item
// o_chunk   | source  | valid / ready | one window-bounded chunk item
// i_cfg_*   | -       | write enable  | window_base, window_end, offset_mask
//
// A region is taken, then each chunk runs the local, room, compare, device, emit
// and offset steps; a split chunk adds the bytes and low-address steps, and the
// high-address step if the low host address carries. A chunk item waits in emit
// on o_chunk.ready. A region gives 1 to MAX_CHUNKS chunks. The address, room,
// compare and byte-count steps take turns on the single 34-bit add/subtract unit.
// Reset: synchronous, active low; restores the register defaults and clears
// the running device offset. A stalled chunk item holds every field.
module scatter_region_window_chunker_core #(
    parameter int unsigned MAX_CHUNKS = 33
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [srwc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [srwc_pkg::CFG_DAT_W-1:0]       i_cfg_wdata,
    srwc_region_if.sink                          i_region,
    srwc_chunk_if.source                         o_chunk
);
    localparam int unsigned CNT_W = (MAX_CHUNKS > 2) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CHUNKS - 1);

    srwc_pkg::t_state r_state, n_state;

    // Configuration
    logic [srwc_pkg::ADDR_W-1:0] r_win_base, n_win_base;
    logic [srwc_pkg::END_W-1:0]  r_win_end,  n_win_end;
    logic [srwc_pkg::ADDR_W-1:0] r_ofs_mask, n_ofs_mask;

    // Running state across regions
    logic [srwc_pkg::ADDR_W-1:0] r_dev_ofs, n_dev_ofs;
    logic [CNT_W-1:0]            r_count,   n_count;

    // Per-region working registers
    logic                        r_mode,     n_mode;
    logic [srwc_pkg::ADDR_W-1:0] r_hi,       n_hi;
    logic [srwc_pkg::ADDR_W-1:0] r_lo,       n_lo;
    logic [srwc_pkg::SIZE_W-1:0] r_left,     n_left;
    logic [srwc_pkg::ADDR_W-1:0] r_dev_base, n_dev_base;
    logic                        r_last_reg, n_last_reg;
    logic [srwc_pkg::ADDR_W-1:0] r_local,    n_local;
    logic [srwc_pkg::END_W-1:0]  r_room,     n_room;
    logic                        r_room_ok,  n_room_ok;
    logic [srwc_pkg::SIZE_W-1:0] r_chunk,    n_chunk;
    logic                        r_last,     n_last;
    logic [srwc_pkg::ADDR_W-1:0] r_dev,      n_dev;

    srwc_pkg::t_alu_op   alu_op;
    srwc_pkg::t_alu_word alu_a, alu_b, alu_res;
    logic                split;

    srwc_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Split only while the window has room, that room is short of what is
    // left, and the chunk limit is not reached.
    assign split = r_room_ok && alu_res[srwc_pkg::ALU_W-1] && (r_count < CNT_LAST);

    always_comb begin
        n_state    = r_state;
        n_win_base = r_win_base;
        n_win_end  = r_win_end;
        n_ofs_mask = r_ofs_mask;
        n_dev_ofs  = r_dev_ofs;
        n_count    = r_count;
        n_mode     = r_mode;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_left     = r_left;
        n_dev_base = r_dev_base;
        n_last_reg = r_last_reg;
        n_local    = r_local;
        n_room     = r_room;
        n_room_ok  = r_room_ok;
        n_chunk    = r_chunk;
        n_last     = r_last;
        n_dev      = r_dev;
        alu_op     = srwc_pkg::ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;

        // Register writes; unused index is dropped
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srwc_pkg::CFG_WIN_BASE: n_win_base = i_cfg_wdata[srwc_pkg::ADDR_W-1:0];
                srwc_pkg::CFG_WIN_END:  n_win_end  = i_cfg_wdata;
                srwc_pkg::CFG_OFS_MASK: n_ofs_mask = i_cfg_wdata[srwc_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            srwc_pkg::ST_IDLE: begin
                if (i_region.valid) begin
                    n_mode     = i_region.mode;
                    n_hi       = i_region.region_addr_hi;
                    n_lo       = i_region.region_addr_lo;
                    n_left     = i_region.region_size;
                    n_dev_base = i_region.device_base;
                    n_last_reg = i_region.last_region;
                    n_count    = '0;
                    n_state    = srwc_pkg::ST_LOCAL;
                end
            end
            srwc_pkg::ST_LOCAL: begin
                // local = window_base + masked low address, wraps at 32 bits
                alu_a   = {2'b00, r_win_base};
                alu_b   = {2'b00, r_lo & r_ofs_mask};
                n_local = alu_res[srwc_pkg::ADDR_W-1:0];
                n_state = srwc_pkg::ST_ROOM;
            end
            srwc_pkg::ST_ROOM: begin
                alu_op    = srwc_pkg::ALU_SUB;
                alu_a     = {1'b0, r_win_end};
                alu_b     = {2'b00, r_local};
                n_room    = alu_res[srwc_pkg::END_W-1:0];
                n_room_ok = !alu_res[srwc_pkg::ALU_W-1] &&
                            (alu_res[srwc_pkg::END_W-1:0] != '0);
                n_state   = srwc_pkg::ST_CMP;
            end
            srwc_pkg::ST_CMP: begin
                // borrow means room < bytes left
                alu_op  = srwc_pkg::ALU_SUB;
                alu_a   = {1'b0, r_room};
                alu_b   = {{(srwc_pkg::ALU_W - srwc_pkg::SIZE_W){1'b0}}, r_left};
                n_chunk = split ? r_room[srwc_pkg::SIZE_W-1:0] : r_left;
                n_last  = !split;
                n_state = srwc_pkg::ST_DEV;
            end
            srwc_pkg::ST_DEV: begin
                alu_a   = {2'b00, r_dev_base};
                alu_b   = {2'b00, r_dev_ofs};
                n_dev   = alu_res[srwc_pkg::ADDR_W-1:0];
                n_state = srwc_pkg::ST_EMIT;
            end
            srwc_pkg::ST_EMIT: begin
                if (o_chunk.ready) begin
                    n_state = srwc_pkg::ST_OFS;
                end
            end
            srwc_pkg::ST_OFS: begin
                alu_a = {2'b00, r_dev_ofs};
                alu_b = {{(srwc_pkg::ALU_W - srwc_pkg::SIZE_W){1'b0}}, r_chunk};
                if (r_last) begin
                    // Clear the offset after the final region of a request
                    n_dev_ofs = r_last_reg ? '0 : alu_res[srwc_pkg::ADDR_W-1:0];
                    n_state   = srwc_pkg::ST_IDLE;
                end else begin
                    n_dev_ofs = alu_res[srwc_pkg::ADDR_W-1:0];
                    n_state   = srwc_pkg::ST_BYTES;
                end
            end
            srwc_pkg::ST_BYTES: begin
                alu_op  = srwc_pkg::ALU_SUB;
                alu_a   = {{(srwc_pkg::ALU_W - srwc_pkg::SIZE_W){1'b0}}, r_left};
                alu_b   = {{(srwc_pkg::ALU_W - srwc_pkg::SIZE_W){1'b0}}, r_chunk};
                n_left  = alu_res[srwc_pkg::SIZE_W-1:0];
                n_state = srwc_pkg::ST_LO;
            end
            srwc_pkg::ST_LO: begin
                // Advance the low host address; a carry goes on to the high word
                alu_a   = {2'b00, r_lo};
                alu_b   = {{(srwc_pkg::ALU_W - srwc_pkg::SIZE_W){1'b0}}, r_chunk};
                n_lo    = alu_res[srwc_pkg::ADDR_W-1:0];
                n_count = r_count + 1'b1;
                n_state = alu_res[srwc_pkg::ADDR_W] ? srwc_pkg::ST_HI : srwc_pkg::ST_LOCAL;
            end
            srwc_pkg::ST_HI: begin
                alu_a   = {2'b00, r_hi};
                alu_b   = {{(srwc_pkg::ALU_W - 1){1'b0}}, 1'b1};
                n_hi    = alu_res[srwc_pkg::ADDR_W-1:0];
                n_state = srwc_pkg::ST_LOCAL;
            end
            default: n_state = srwc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= srwc_pkg::ST_IDLE;
            r_win_base <= srwc_pkg::WIN_BASE_RST;
            r_win_end  <= srwc_pkg::WIN_END_RST;
            r_ofs_mask <= srwc_pkg::OFS_MASK_RST;
            r_dev_ofs  <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_win_base <= n_win_base;
            r_win_end  <= n_win_end;
            r_ofs_mask <= n_ofs_mask;
            r_dev_ofs  <= n_dev_ofs;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_left     <= n_left;
        r_dev_base <= n_dev_base;
        r_last_reg <= n_last_reg;
        r_local    <= n_local;
        r_room     <= n_room;
        r_room_ok  <= n_room_ok;
        r_chunk    <= n_chunk;
        r_last     <= n_last;
        r_dev      <= n_dev;
    end

    // Take a new region only when the previous one is fully delivered
    assign i_region.ready      = (r_state == srwc_pkg::ST_IDLE);

    // Chunk fields come straight from registers and hold while stalled
    assign o_chunk.valid       = (r_state == srwc_pkg::ST_EMIT);
    assign o_chunk.bar_addr_hi = r_hi;
    assign o_chunk.bar_addr_lo = r_lo;
    assign o_chunk.src_addr    = r_mode ? r_local : r_dev;
    assign o_chunk.dst_addr    = r_mode ? r_dev : r_local;
    assign o_chunk.chunk_size  = r_chunk;
    assign o_chunk.last_chunk  = r_last;

endmodule

// ===== hw/rtl/srwc_chk.sv =====
module srwc_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [srwc_pkg::SIZE_W-1:0] i_chunk_size,
    input logic                        i_last_chunk
);
    // One region at a time: no new item while a chunk is on offer
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("region taken while a chunk is pending");

    // A taken region blocks the input on the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after taking a region");

    // More chunks follow a non-final one, so the input stays closed
    a_busy_mid_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_chunk) |=> !i_in_ready)
        else $error("input opened before the final chunk");

    // A split chunk always moves at least one byte
    a_split_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last_chunk) |-> (i_chunk_size != '0))
        else $error("empty chunk before the final one");

    // Stalled chunk holds its size
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_chunk_size)))
        else $error("stalled chunk changed");
endmodule

bind scatter_region_window_chunker_core srwc_chk u_srwc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_region.valid),
    .i_in_ready   (i_region.ready),
    .i_out_valid  (o_chunk.valid),
    .i_out_ready  (o_chunk.ready),
    .i_chunk_size (o_chunk.chunk_size),
    .i_last_chunk (o_chunk.last_chunk)
);

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ADDR_W    = srwc_pkg::ADDR_W;
    localparam int unsigned SIZE_W    = srwc_pkg::SIZE_W;
    localparam int unsigned END_W     = srwc_pkg::END_W;
    localparam int unsigned CFG_IDX_W = srwc_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DAT_W = srwc_pkg::CFG_DAT_W;

    // Chunk cap of this build; the last chunk allowed carries whatever is left.
    localparam int unsigned CHUNK_LIMIT = 33;
    // Index past the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Cycles to let the block settle once the last chunk item has gone.
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 25'h100_0000;

    typedef struct {
        logic              mode;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] dev_base;
        logic              last;
    } t_region;

    typedef struct {
        logic [ADDR_W-1:0] bar_hi;
        logic [ADDR_W-1:0] bar_lo;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [SIZE_W-1:0] size;
        logic              last;
    } t_chunk;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    srwc_region_if region_ch ();
    srwc_chunk_if  chunk_ch ();

    scatter_region_window_chunker_core #(
        .MAX_CHUNKS (CHUNK_LIMIT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_region    (region_ch.sink),
        .o_chunk     (chunk_ch.source)
    );

    // Shadow of the window registers and of the running device offset.
    logic [ADDR_W-1:0] win_base = srwc_pkg::WIN_BASE_RST;
    logic [END_W-1:0]  win_end  = srwc_pkg::WIN_END_RST;
    logic [ADDR_W-1:0] ofs_mask = srwc_pkg::OFS_MASK_RST;
    logic [ADDR_W-1:0] dev_ofs  = '0;

    // Chunk items still owed by the block, oldest first.
    t_chunk expected_chunks[$];
    t_chunk head_chunk;
    int     err_count = 0;

    // Idling controls: steady flags give stretches with no gaps at all.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_stall_left = 0;
    int rx_hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung block well after the slowest correct run.
    initial begin
        #10ms;
        $display("** scatter_region_window_chunker_core: FAILED **");
        $finish;
    end

    // Walk one region over the window exactly as the block must, queueing every chunk.
    function automatic void predict_chunks(t_region r);
        logic [ADDR_W-1:0] hi, lo, loc, dev;
        logic [ADDR_W:0]   lo_sum;
        logic [END_W-1:0]  room;
        logic [SIZE_W-1:0] left, sz;
        int unsigned       n;
        bit                done;
        t_chunk            c;
        hi   = r.addr_hi;
        lo   = r.addr_lo;
        left = r.size;
        n    = 0;
        done = 1'b0;
        while (!done) begin
            loc  = win_base + (lo & ofs_mask);
            dev  = r.dev_base + dev_ofs;
            room = win_end - {1'b0, loc};
            // Split only while the window has room short of what remains
            // and the chunk cap is not yet reached.
            if (win_end > {1'b0, loc} && room < {8'd0, left} && n + 1 < CHUNK_LIMIT) begin
                sz = room[SIZE_W-1:0];
            end else begin
                sz   = left;
                done = 1'b1;
            end
            c.bar_hi = hi;
            c.bar_lo = lo;
            c.src    = r.mode ? loc : dev;
            c.dst    = r.mode ? dev : loc;
            c.size   = sz;
            c.last   = done;
            expected_chunks.push_back(c);
            n++;
            dev_ofs = dev_ofs + {7'd0, sz};
            left    = left - sz;
            if (!done) begin
                // Advance the 64-bit host address with carry into the top word.
                lo_sum = {1'b0, lo} + {8'd0, sz};
                if (lo_sum[ADDR_W])
                    hi = hi + 1;
                lo = lo_sum[ADDR_W-1:0];
            end
        end
        if (r.last)
            dev_ofs = '0;
    endfunction

    function automatic t_region make_region(logic mode, logic [ADDR_W-1:0] hi,
                                            logic [ADDR_W-1:0] lo, logic [SIZE_W-1:0] size,
                                            logic [ADDR_W-1:0] dev, logic last);
        t_region r;
        r.mode     = mode;
        r.addr_hi  = hi;
        r.addr_lo  = lo;
        r.size     = size;
        r.dev_base = dev;
        r.last     = last;
        return r;
    endfunction

    // Random region aimed at the current window: often right at its edge,
    // sometimes about to carry into the top address word.
    function automatic t_region rand_region(logic mode, logic [ADDR_W-1:0] dev, logic last);
        t_region          r;
        logic [END_W-1:0] span;
        longint unsigned  cap;
        span = (win_end > {1'b0, win_base}) ? win_end - {1'b0, win_base} : 33'd4096;
        cap  = 3 * longint'(span);
        if (cap > SIZE_MAX)
            cap = SIZE_MAX;
        r.mode     = mode;
        r.dev_base = dev;
        r.last     = last;
        r.addr_hi  = ($urandom_range(0, 9) == 0) ? '1 : $urandom;
        r.addr_lo  = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: r.addr_lo = (r.addr_lo & ~ofs_mask)
                               | ((span[ADDR_W-1:0] - $urandom_range(1, 256)) & ofs_mask);
            3:       r.addr_lo = 32'hFFFF_FFFF - $urandom_range(0, 4095);
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0:       r.size = '0;
            1:       r.size = SIZE_MAX;
            2, 3:    r.size = $urandom_range(0, SIZE_MAX);
            default: r.size = $urandom_range(1, int'(cap));
        endcase
        return r;
    endfunction

    // Offer one region item and hold it until the block takes it.
    task automatic send_region(t_region r);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge i_clk);
            region_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        region_ch.mode           <= r.mode;
        region_ch.region_addr_hi <= r.addr_hi;
        region_ch.region_addr_lo <= r.addr_lo;
        region_ch.region_size    <= r.size;
        region_ch.device_base    <= r.dev_base;
        region_ch.last_region    <= r.last;
        region_ch.valid          <= 1'b1;
        do @(posedge i_clk); while (region_ch.ready !== 1'b1);
        predict_chunks(r);
    endtask

    // Drop valid and hold until every owed chunk item has come, then let the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        region_ch.valid <= 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write per falling edge; the enable stays high across a burst.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            srwc_pkg::CFG_WIN_BASE: win_base = data[ADDR_W-1:0];
            srwc_pkg::CFG_WIN_END:  win_end  = data;
            srwc_pkg::CFG_OFS_MASK: ofs_mask = data[ADDR_W-1:0];
            default:                ;
        endcase
    endtask

    task automatic end_cfg();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window(logic [CFG_DAT_W-1:0] base, logic [CFG_DAT_W-1:0] wend,
                              logic [CFG_DAT_W-1:0] mask);
        write_cfg(srwc_pkg::CFG_WIN_BASE, base);
        write_cfg(srwc_pkg::CFG_WIN_END, wend);
        write_cfg(srwc_pkg::CFG_OFS_MASK, mask);
        end_cfg();
    endtask

    // Random window: aligned power-of-two spans mostly, extremes now and then.
    // The unused top data bit is set at random on the 32-bit registers.
    task automatic set_random_window();
        logic [ADDR_W-1:0] base, mask;
        logic [END_W-1:0]  wend;
        int unsigned       k;
        k = $urandom_range(6, 24);
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            default: base = $urandom & ~((32'd1 << k) - 1);
        endcase
        case ($urandom_range(0, 5))
            0:       wend = 33'd1;
            1:       wend = 33'h1_0000_0000;
            2:       wend = {1'b0, $urandom} + 33'd1;
            default: wend = {1'b0, base} + (33'd1 << k);
        endcase
        case ($urandom_range(0, 5))
            0:       mask = '0;
            1:       mask = '1;
            2:       mask = $urandom;
            default: mask = (32'd1 << k) - 1;
        endcase
        set_window({1'($urandom_range(0, 1)), base}, wend, {1'($urandom_range(0, 1)), mask});
    endtask

    // Mostly well-formed requests (one device base and direction, last mark on
    // the final region); about one draw in five is a stray region with random marks.
    task automatic send_random_regions(int unsigned count);
        int unsigned       sent, nreg;
        logic              mode;
        logic [ADDR_W-1:0] dev;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_region(rand_region($urandom_range(0, 1), $urandom, $urandom_range(0, 1)));
                sent++;
            end else begin
                nreg = $urandom_range(1, 6);
                mode = $urandom_range(0, 1);
                dev  = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                   : $urandom;
                for (int unsigned i = 0; i < nreg; i++)
                    send_region(rand_region(mode, dev, i == nreg - 1));
                sent += nreg;
            end
        end
    endtask

    // Reset window: empty regions, a region of SIZE_MAX bytes, carry and wrap of the
    // host address, wrap of the device address, all-ones fields.
    task automatic test_reset_window();
        send_region(make_region(1'b0, 32'h0, 32'h0, '0, 32'h0, 1'b0));
        send_region(make_region(1'b1, 32'h0, 32'h0, '0, 32'h0, 1'b1));
        send_region(make_region(1'b1, 32'h1234_5678, 32'h0, SIZE_MAX, 32'hFFFF_FFF0, 1'b0));
        send_region(make_region(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FF00, 25'h1000,
                                32'hFFFF_FFF0, 1'b1));
        send_region(make_region(1'b1, '1, '1, 25'd1, '1, 1'b1));
        wait_drained();
    endtask

    // Tiny window: the chunk cap ends the split and the capped chunk takes the rest.
    task automatic test_chunk_cap();
        set_window(33'h0, 33'h1000, 33'hFFF);
        send_region(make_region(1'b0, 32'h0, 32'h800, SIZE_MAX, 32'h1000_0000, 1'b0));
        send_region(make_region(1'b1, 32'h0, 32'h0, 25'(33 * 4096), 32'h1000_0000, 1'b1));
        wait_drained();
    endtask

    // Window edges: no room left, the widest and narrowest windows, local
    // address wrap, a zero mask and a write to the unused index.
    task automatic test_window_edges();
        set_window(33'hFFFF_F000, 33'h1000, 33'hFFF);
        send_region(make_region(1'b0, 32'h5, 32'h0000_0ABC, 25'h5000, 32'h100, 1'b1));
        wait_drained();
        set_window(33'hFFFF_0000, 33'h1_0000_0000, 33'h1_0001_FFFF);
        send_region(make_region(1'b1, 32'h7, 32'hABCD_8000, 25'h20000, 32'h2000, 1'b0));
        send_region(make_region(1'b0, 32'h7, 32'h0001_0010, 25'h20000, 32'h2000, 1'b1));
        wait_drained();
        set_window(33'h0, 33'd1, 33'h0);
        send_region(make_region(1'b0, 32'h0, 32'hDEAD_BEEF, 25'd100, 32'h0, 1'b0));
        send_region(make_region(1'b1, 32'h0, 32'h0000_0001, 25'd1, 32'h0, 1'b1));
        wait_drained();
        set_window(33'h1_8000_0000, 33'h8000_1000, 33'h0);
        write_cfg(CFG_UNUSED, '1);
        end_cfg();
        send_region(make_region(1'b1, 32'h1, 32'hFFFF_FFFF, 25'h3000, 32'h4000, 1'b1));
        send_region(make_region(1'b0, 32'h1, 32'h0, 25'h1000, 32'h4000, 1'b1));
        wait_drained();
    endtask

    // Several random windows with random regions; some phases run without idling.
    task automatic test_random_windows();
        for (int unsigned phase = 0; phase < 6; phase++) begin
            set_random_window();
            tx_steady = (phase == 1);
            rx_steady = (phase == 1 || phase == 4);
            send_random_regions(52);
            wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Hold off the chunk side for a long stretch while regions keep coming,
    // so the block backs up into its input.
    task automatic test_output_hold();
        set_window(33'h0, 33'h4000, 33'h3FFF);
        rx_hold_left = 600;
        send_random_regions(16);
        wait_drained();
    endtask

    // Pace the sender: one region at a time, each drained before the next.
    task automatic test_paced_regions();
        set_random_window();
        for (int unsigned i = 0; i < 10; i++) begin
            send_region(rand_region($urandom_range(0, 1), $urandom, $urandom_range(0, 1)));
            wait_drained();
        end
    endtask

    // Chunk receiver: hold, then random stalls, otherwise ready.
    initial begin
        chunk_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                chunk_ch.ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_stall_left > 0) begin
                chunk_ch.ready <= 1'b0;
                rx_stall_left--;
            end else begin
                chunk_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: chunk %s mismatch, expected %h, actual %h", $time, fname, want, got);
            err_count++;
        end
    endtask

    // Compare every accepted chunk item with the oldest one owed, then draw the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && chunk_ch.valid === 1'b1 && chunk_ch.ready === 1'b1) begin
            if (expected_chunks.size() == 0) begin
                $display("%0t: unexpected chunk item, expected none, actual bar %h_%h size %h",
                         $time, chunk_ch.bar_addr_hi, chunk_ch.bar_addr_lo, chunk_ch.chunk_size);
                err_count++;
            end else begin
                head_chunk = expected_chunks.pop_front();
                check_field("bar_addr_hi", head_chunk.bar_hi, chunk_ch.bar_addr_hi);
                check_field("bar_addr_lo", head_chunk.bar_lo, chunk_ch.bar_addr_lo);
                check_field("src_addr", head_chunk.src, chunk_ch.src_addr);
                check_field("dst_addr", head_chunk.dst, chunk_ch.dst_addr);
                check_field("chunk_size", head_chunk.size, chunk_ch.chunk_size);
                check_field("last_chunk", head_chunk.last, chunk_ch.last_chunk);
            end
            rx_stall_left = rx_steady ? 0 : $urandom_range(0, 5);
        end
    end

    initial begin
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_idx                = '0;
        i_cfg_wdata              = '0;
        region_ch.valid          = 1'b0;
        region_ch.mode           = 1'b0;
        region_ch.region_addr_hi = '0;
        region_ch.region_addr_lo = '0;
        region_ch.region_size    = '0;
        region_ch.device_base    = '0;
        region_ch.last_region    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_chunk_cap();
        test_window_edges();
        test_random_windows();
        test_output_hold();
        test_paced_regions();

        wait_drained();
        if (err_count == 0) begin
            $display("** scatter_region_window_chunker_core: PASSED **");
        end else begin
            $display("** scatter_region_window_chunker_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== scatter_region_window_chunker_core.f =====
hw/rtl/srwc_pkg.sv
hw/rtl/srwc_region_if.sv
hw/rtl/srwc_chunk_if.sv
hw/rtl/srwc_alu.sv
hw/rtl/scatter_region_window_chunker_core.sv
hw/rtl/srwc_chk.sv
bench/testbench.sv
